// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the allocation tracking table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/att_pkg.sv =====
// Types and constants of the allocation tracking table.
package att_pkg;

    localparam int ADDR_W      = 64;
    localparam int SIZE_W      = 32;
    localparam int CNT_W       = 64;
    localparam int LIVE_W      = 7;
    localparam int STATUS_W    = 3;
    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 304;
    localparam int M_PAD_W     = 6;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_RECORDED  = 3'd0,
        STAT_NULL      = 3'd1,
        STAT_RELEASED  = 3'd2,
        STAT_UNTRACKED = 3'd3,
        STAT_FULL      = 3'd4
    } att_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_FIND,
        ST_FIND_END,
        ST_EVAL,
        ST_FIX,
        ST_FIX_END,
        ST_DONE
    } att_state_t;

endpackage

// ===== rtl/core/att_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module att_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/allocation_tracking_table_core.sv =====
// Allocation tracking table: records allocations and matches releases by address.
//
// Each accepted event returns exactly one result transfer. Entries (address, size and
// recording rank) live in one RAM with a registered read port; live flags sit in
// flip-flops, so no clearing pass follows reset. A null event or an allocation into a
// full table goes straight to its result without a walk. An allocation walks the live
// flags one slot a cycle, from slot 0 up to the lowest free slot. A release walks the
// entry RAM through its single read port to find the newest matching entry; a match
// adds a second walk to renumber the younger entries. A new event is taken while the
// previous result still waits on the master side, and its own result waits until that
// transfer completes.
`include "assert_macros.svh"

module allocation_tracking_table_core
    import att_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // block_address [63:0], alloc_size [95:64]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func [0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status [2:0], released_size [34:3], usage_now [98:35], usage_peak [162:99],
    // allocated_total [226:163], freed_total [290:227], live_count [297:291], zeros above
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = ADDR_W + SIZE_W + IW;

    att_state_t            state_reg, state_next;
    att_status_t           status_reg, status_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [IW-1:0]         scan_idx_reg, scan_idx_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [IW-1:0]         chk_idx_reg, chk_idx_next;
    logic                  found_reg, found_next;
    logic [IW-1:0]         best_idx_reg, best_idx_next;
    logic [IW-1:0]         best_age_reg, best_age_next;
    logic [SIZE_W-1:0]     best_size_reg, best_size_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]      cur_reg, cur_next;
    logic [CNT_W-1:0]      peak_reg, peak_next;
    logic [CNT_W-1:0]      alloc_sum_reg, alloc_sum_next;
    logic [CNT_W-1:0]      freed_sum_reg, freed_sum_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic                  ram_wr_en;
    logic [IW-1:0]         ram_wr_addr;
    logic [EW-1:0]         ram_wr_data;
    logic                  ram_rd_en;
    logic [IW-1:0]         ram_rd_addr;
    logic [EW-1:0]         ram_rd_data;

    logic [ADDR_W-1:0]     rd_addr;
    logic [SIZE_W-1:0]     rd_size;
    logic [IW-1:0]         rd_age;
    logic                  hit;
    logic                  younger;
    logic [CNT_W-1:0]      cur_add;
    logic [CNT_W-1:0]      cur_sub;
    logic [CW+LIVE_W-1:0]  live_ext;

    att_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_addr = ram_rd_data[EW-1 -: ADDR_W];
    assign rd_size = ram_rd_data[IW +: SIZE_W];
    assign rd_age  = ram_rd_data[IW-1:0];

    assign hit = chk_vld_reg && valid_reg[chk_idx_reg] && (rd_addr == addr_reg)
                 && (!found_reg || (rd_age > best_age_reg));
    assign younger = chk_vld_reg && valid_reg[chk_idx_reg] && (rd_age > best_age_reg);

    assign cur_add = cur_reg + {{(CNT_W-SIZE_W){1'b0}}, size_reg};
    assign cur_sub = cur_reg - {{(CNT_W-SIZE_W){1'b0}}, best_size_reg};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        addr_next      = addr_reg;
        size_next      = size_reg;
        scan_idx_next  = scan_idx_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = scan_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_age_next  = best_age_reg;
        best_size_next = best_size_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        peak_next      = peak_reg;
        alloc_sum_next = alloc_sum_reg;
        freed_sum_next = freed_sum_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        live_ext       = {{LIVE_W{1'b0}}, count_reg};
        ram_wr_en      = 1'b0;
        ram_wr_addr    = chk_idx_reg;
        ram_wr_data    = {rd_addr, rd_size, rd_age - 1'b1};
        ram_rd_en      = 1'b0;
        ram_rd_addr    = scan_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    addr_next      = s_tdata[ADDR_W-1:0];
                    size_next      = s_tdata[ADDR_W +: SIZE_W];
                    scan_idx_next  = '0;
                    found_next     = 1'b0;
                    best_size_next = '0;
                    priority if (s_tdata[ADDR_W-1:0] == '0) begin
                        status_next = STAT_NULL;
                        state_next  = ST_DONE;
                    end else if (s_tuser == FUNC_ALLOC) begin
                        if (count_reg == CW'(TABLE_DEPTH)) begin
                            status_next = STAT_FULL;
                            state_next  = ST_DONE;
                        end else begin
                            state_next = ST_ALLOC;
                        end
                    end else begin
                        state_next = ST_FIND;
                    end
                end
            end
            ST_ALLOC: begin
                if (!valid_reg[scan_idx_reg]) begin
                    ram_wr_en     = 1'b1;
                    ram_wr_addr   = scan_idx_reg;
                    ram_wr_data   = {addr_reg, size_reg, count_reg[IW-1:0]};
                    best_idx_next = scan_idx_reg;
                    status_next   = STAT_RECORDED;
                    state_next    = ST_DONE;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_FIND, ST_FIX: begin
                ram_rd_en    = 1'b1;
                chk_vld_next = 1'b1;
                if (state_reg == ST_FIND) begin
                    if (hit) begin
                        found_next     = 1'b1;
                        best_idx_next  = chk_idx_reg;
                        best_age_next  = rd_age;
                        best_size_next = rd_size;
                    end
                end else if (younger) begin
                    ram_wr_en = 1'b1;
                end
                if (scan_idx_reg == IW'(TABLE_DEPTH - 1)) begin
                    state_next = (state_reg == ST_FIND) ? ST_FIND_END : ST_FIX_END;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_FIND_END: begin
                if (hit) begin
                    found_next     = 1'b1;
                    best_idx_next  = chk_idx_reg;
                    best_age_next  = rd_age;
                    best_size_next = rd_size;
                end
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (found_reg) begin
                    scan_idx_next = '0;
                    state_next    = ST_FIX;
                end else begin
                    status_next = STAT_UNTRACKED;
                    state_next  = ST_DONE;
                end
            end
            ST_FIX_END: begin
                if (younger) begin
                    ram_wr_en = 1'b1;
                end
                status_next = STAT_RELEASED;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    unique case (status_reg)
                        STAT_RECORDED: begin
                            valid_next[best_idx_reg] = 1'b1;
                            count_next     = count_reg + 1'b1;
                            alloc_sum_next = alloc_sum_reg + {{(CNT_W-SIZE_W){1'b0}}, size_reg};
                            cur_next       = cur_add;
                            peak_next      = (cur_add > peak_reg) ? cur_add : peak_reg;
                        end
                        STAT_RELEASED: begin
                            valid_next[best_idx_reg] = 1'b0;
                            count_next     = count_reg - 1'b1;
                            freed_sum_next = freed_sum_reg
                                             + {{(CNT_W-SIZE_W){1'b0}}, best_size_reg};
                            cur_next       = cur_sub;
                        end
                        default: begin
                        end
                    endcase
                    live_ext      = {{LIVE_W{1'b0}}, count_next};
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{M_PAD_W{1'b0}}, live_ext[LIVE_W-1:0], freed_sum_next,
                                     alloc_sum_next, peak_next, cur_next, best_size_reg,
                                     status_reg};
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chk_vld_reg   <= 1'b0;
            valid_reg     <= '0;
            count_reg     <= '0;
            cur_reg       <= '0;
            peak_reg      <= '0;
            alloc_sum_reg <= '0;
            freed_sum_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chk_vld_reg   <= chk_vld_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            peak_reg      <= peak_next;
            alloc_sum_reg <= alloc_sum_next;
            freed_sum_reg <= freed_sum_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        addr_reg      <= addr_next;
        size_reg      <= size_next;
        scan_idx_reg  <= scan_idx_next;
        chk_idx_reg   <= chk_idx_next;
        found_reg     <= found_next;
        best_idx_reg  <= best_idx_next;
        best_age_reg  <= best_age_next;
        best_size_reg <= best_size_next;
        m_tdata_reg   <= m_tdata_next;
    end

    `ASSERT_ALWAYS(a_count_matches_valid, aclk, aresetn,
        $countones(valid_reg) == count_reg,
        "live count differs from the number of live flags")
    `ASSERT_ALWAYS(a_count_in_range, aclk, aresetn,
        count_reg <= CW'(TABLE_DEPTH),
        "live count exceeds the table depth")
    `ASSERT_IMPLIES(a_no_write_in_search, aclk, aresetn,
        (state_reg == ST_FIND) || (state_reg == ST_FIND_END) || (state_reg == ST_EVAL),
        !ram_wr_en, "entry RAM written during the search walk")
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn,
        s_tvalid && s_tready, state_reg != ST_IDLE,
        "input transfer accepted without starting work")

endmodule
